>>> hdl/eia_pkg.sv
package eia_pkg;

    localparam int ENTITY_SLOTS = 256;
    localparam int ID_W         = $clog2(ENTITY_SLOTS);
    localparam int CNT_W        = $clog2(ENTITY_SLOTS + 1);
    localparam int SIG_W        = 32;
    localparam int META_W       = SIG_W + 2;

    typedef enum logic [2:0] {
        OP_CREATE     = 3'd0,
        OP_DESTROY    = 3'd1,
        OP_SET_SIG    = 3'd2,
        OP_READ       = 3'd3,
        OP_SET_ENABLE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_ACTIVE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_META
    } t_state;

    typedef struct packed {
        logic take;
        logic meta_from_stack;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic can_take;
        logic pop;
    } t_ctl_status;

endpackage

>>> hdl/eia_req_if.sv
interface eia_req_if;
    import eia_pkg::*;

    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [ID_W-1:0]   entity;
    logic [SIG_W-1:0]  signature_in;
    logic              enable_value;

    modport source (output valid, operation, entity, signature_in, enable_value,
                    input ready);
    modport sink   (input valid, operation, entity, signature_in, enable_value,
                    output ready);
endinterface

>>> hdl/eia_rsp_if.sv
interface eia_rsp_if;
    import eia_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   entity_out;
    logic [SIG_W-1:0]  signature_out;
    logic              is_active;
    logic              is_enabled;
    logic [CNT_W-1:0]  active_count;
    logic [1:0]        status;

    modport source (output valid, entity_out, signature_out, is_active, is_enabled,
                    active_count, status, input ready);
    modport sink   (input valid, entity_out, signature_out, is_active, is_enabled,
                    active_count, status, output ready);
endinterface

>>> hdl/eia_ram.sv
module eia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/eia_ctrl.sv
module eia_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  eia_pkg::t_ctl_status  i_status,
    output logic                  o_req_ready,
    output eia_pkg::t_ctl_cmd     o_cmd
);
    import eia_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = i_status.can_take;
                if (i_req_valid && i_status.can_take) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_status.pop ? S_POP : S_META;
                end
            end
            S_POP: begin
                o_cmd.meta_from_stack = 1'b1;
                n_state               = S_META;
            end
            S_META: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> hdl/eia_datapath.sv
module eia_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eia_pkg::t_ctl_cmd            i_cmd,
    output eia_pkg::t_ctl_status         o_ctl_status,
    input  logic [2:0]                   i_operation,
    input  logic [eia_pkg::ID_W-1:0]     i_entity,
    input  logic [eia_pkg::SIG_W-1:0]    i_signature_in,
    input  logic                         i_enable_value,
    input  logic                         i_rsp_ready,
    output logic                         o_rsp_valid,
    output logic [eia_pkg::ID_W-1:0]     o_entity_out,
    output logic [eia_pkg::SIG_W-1:0]    o_signature_out,
    output logic                         o_is_active,
    output logic                         o_is_enabled,
    output logic [eia_pkg::CNT_W-1:0]    o_active_count,
    output logic [1:0]                   o_status
);
    import eia_pkg::*;

    // control state
    logic [CNT_W-1:0]        r_depth, n_depth;
    logic [CNT_W-1:0]        r_fresh, n_fresh;
    logic [CNT_W-1:0]        r_live, n_live;
    logic [ENTITY_SLOTS-1:0] r_valid;
    logic                    r_out_valid;

    // request and result payload
    t_op                     r_op;
    logic [SIG_W-1:0]        r_sig;
    logic                    r_en;
    logic [ID_W-1:0]         r_nid;
    logic                    r_full;
    logic                    r_vld_rd;
    logic [ID_W-1:0]         r_out_entity;
    logic [SIG_W-1:0]        r_out_sig;
    logic                    r_out_act;
    logic                    r_out_en;
    logic [CNT_W-1:0]        r_out_count;
    t_status                 r_out_status;

    t_op                     in_op;
    logic                    pool_full;
    logic                    pop;
    logic [CNT_W-1:0]        depth_m1;
    logic [ID_W-1:0]         take_id;

    logic                    stack_re;
    logic                    stack_we;
    logic [ID_W-1:0]         stack_rdata;
    logic                    meta_re;
    logic [ID_W-1:0]         meta_raddr;
    logic                    meta_we;
    logic [META_W-1:0]       meta_wdata;
    logic [META_W-1:0]       meta_rdata;

    logic [SIG_W-1:0]        cur_sig;
    logic                    cur_act;
    logic                    cur_en;
    logic [SIG_W-1:0]        res_sig;
    logic                    res_act;
    logic                    res_en;
    t_status                 res_status;

    assign in_op     = t_op'(i_operation);
    assign pool_full = (r_live >= CNT_W'(ENTITY_SLOTS)) ||
                       ((r_depth == '0) && (r_fresh >= CNT_W'(ENTITY_SLOTS)));
    assign pop       = (in_op == OP_CREATE) && !pool_full && (r_depth != '0);
    assign depth_m1  = r_depth - 1'b1;

    always_comb begin
        if (in_op == OP_CREATE) begin
            take_id = pool_full ? '0 : r_fresh[ID_W-1:0];
        end else begin
            take_id = i_entity;
        end
    end

    assign o_ctl_status.can_take = !r_out_valid || i_rsp_ready;
    assign o_ctl_status.pop      = pop;

    assign stack_re   = i_cmd.take && pop;
    assign meta_re    = (i_cmd.take && !pop) || i_cmd.meta_from_stack;
    assign meta_raddr = i_cmd.meta_from_stack ? stack_rdata : take_id;

    eia_ram #(
        .WIDTH (ID_W),
        .DEPTH (ENTITY_SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_depth[ID_W-1:0]),
        .i_wdata (r_nid),
        .i_re    (stack_re),
        .i_raddr (depth_m1[ID_W-1:0]),
        .o_rdata (stack_rdata)
    );

    eia_ram #(
        .WIDTH (META_W),
        .DEPTH (ENTITY_SLOTS)
    ) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_nid),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    // never-written entries read as cleared
    assign cur_sig = r_vld_rd ? meta_rdata[META_W-1:2] : '0;
    assign cur_act = r_vld_rd ? meta_rdata[1] : 1'b0;
    assign cur_en  = r_vld_rd ? meta_rdata[0] : 1'b0;

    always_comb begin
        n_depth    = r_depth;
        n_fresh    = r_fresh;
        n_live     = r_live;
        res_sig    = cur_sig;
        res_act    = cur_act;
        res_en     = cur_en;
        res_status = ST_OK;
        meta_we    = 1'b0;
        stack_we   = 1'b0;
        unique case (r_op)
            OP_CREATE: begin
                if (r_full) begin
                    res_status = ST_FULL;
                end else begin
                    meta_we = 1'b1;
                    res_act = 1'b1;
                    res_en  = 1'b1;
                    n_live  = r_live + 1'b1;
                    if (r_depth != '0) begin
                        n_depth = r_depth - 1'b1;
                    end else begin
                        n_fresh = r_fresh + 1'b1;
                    end
                end
            end
            OP_DESTROY: begin
                if (!cur_act) begin
                    res_status = ST_NOT_ACTIVE;
                end else begin
                    meta_we = 1'b1;
                    res_sig = '0;
                    res_act = 1'b0;
                    res_en  = 1'b0;
                    if (r_depth < CNT_W'(ENTITY_SLOTS)) begin
                        stack_we = 1'b1;
                        n_depth  = r_depth + 1'b1;
                    end
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
            end
            OP_SET_SIG: begin
                meta_we = 1'b1;
                res_sig = r_sig;
            end
            OP_SET_ENABLE: begin
                if (!cur_act) begin
                    res_status = ST_NOT_ACTIVE;
                end else begin
                    meta_we = 1'b1;
                    res_en  = r_en;
                end
            end
            default: begin
            end
        endcase
        if (!i_cmd.commit) begin
            meta_we  = 1'b0;
            stack_we = 1'b0;
        end
    end

    assign meta_wdata = {res_sig, res_act, res_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_fresh     <= '0;
            r_live      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_depth <= n_depth;
                r_fresh <= n_fresh;
                r_live  <= n_live;
            end
            if (meta_we) begin
                r_valid[r_nid] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= in_op;
            r_sig  <= i_signature_in;
            r_en   <= i_enable_value;
            r_nid  <= take_id;
            r_full <= (in_op == OP_CREATE) && pool_full;
        end else if (i_cmd.meta_from_stack) begin
            r_nid <= stack_rdata;
        end
        if (meta_re) begin
            r_vld_rd <= r_valid[meta_raddr];
        end
        if (i_cmd.commit) begin
            r_out_entity <= r_nid;
            r_out_sig    <= res_sig;
            r_out_act    <= res_act;
            r_out_en     <= res_en;
            r_out_count  <= n_live;
            r_out_status <= res_status;
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_entity_out    = r_out_entity;
    assign o_signature_out = r_out_sig;
    assign o_is_active     = r_out_act;
    assign o_is_enabled    = r_out_en;
    assign o_active_count  = r_out_count;
    assign o_status        = r_out_status;
endmodule

>>> hdl/entity_id_allocator_core.sv
// Entity ID allocator: one response per request. Create pops a freed ID or
// takes the next fresh one; destroy pushes the ID back and clears its entry.
// A request is accepted and its entry RAM read issued, then the entry is updated;
// a create that reuses a freed ID reads the freed-stack RAM before the entry RAM.
// The next request is accepted only when idle and the response register is free.
// The freed stack and per-ID entry table live in single-port-read RAMs;
// entries never written read as inactive, disabled, zero signature.
module entity_id_allocator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eia_req_if.sink   i_req,
    eia_rsp_if.source o_rsp
);
    import eia_pkg::*;

    t_ctl_cmd    cmd;
    t_ctl_status st;

    eia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (st),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    eia_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_ctl_status    (st),
        .i_operation     (i_req.operation),
        .i_entity        (i_req.entity),
        .i_signature_in  (i_req.signature_in),
        .i_enable_value  (i_req.enable_value),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_entity_out    (o_rsp.entity_out),
        .o_signature_out (o_rsp.signature_out),
        .o_is_active     (o_rsp.is_active),
        .o_is_enabled    (o_rsp.is_enabled),
        .o_active_count  (o_rsp.active_count),
        .o_status        (o_rsp.status)
    );
endmodule
